/* hw/rtl/alt_pkg.sv */
// ----------------------------------------------------------------------------
// alt_pkg
// Types and codes shared by the line tokenizer.
// ----------------------------------------------------------------------------
package alt_pkg;

    typedef enum logic [15:0] {
        M_IDLE     = 16'h0001,
        M_SKIP     = 16'h0002,
        M_IDENT    = 16'h0004,
        M_NUM      = 16'h0008,
        M_HEXX     = 16'h0010,
        M_HEXD     = 16'h0020,
        M_DOLLAR   = 16'h0040,
        M_PERCENT  = 16'h0080,
        M_BIN      = 16'h0100,
        M_STR      = 16'h0200,
        M_STRESC   = 16'h0400,
        M_CHR      = 16'h0800,
        M_CHRESC   = 16'h1000,
        M_CHRCLOSE = 16'h2000,
        M_LT       = 16'h4000,
        M_GT       = 16'h8000
    } t_mode;

    localparam logic [4:0] K_IDCHAR  = 5'd0;
    localparam logic [4:0] K_IDEND   = 5'd1;
    localparam logic [4:0] K_NUM     = 5'd2;
    localparam logic [4:0] K_STRCHAR = 5'd3;
    localparam logic [4:0] K_STREND  = 5'd4;
    localparam logic [4:0] K_DOLLAR  = 5'd5;
    localparam logic [4:0] K_PERCENT = 5'd6;
    localparam logic [4:0] K_PUNCT0  = 5'd7;
    localparam logic [4:0] K_SHL     = 5'd19;
    localparam logic [4:0] K_SHR     = 5'd20;
    localparam logic [4:0] K_EOL     = 5'd21;
    localparam logic [4:0] K_ERR     = 5'd22;

    localparam logic [3:0] E_NONE   = 4'd0;
    localparam logic [3:0] E_HEX    = 4'd1;
    localparam logic [3:0] E_BIN    = 4'd2;
    localparam logic [3:0] E_DEC    = 4'd3;
    localparam logic [3:0] E_OPENS  = 4'd4;
    localparam logic [3:0] E_CHAR   = 4'd5;
    localparam logic [3:0] E_OPENC  = 4'd6;
    localparam logic [3:0] E_LT     = 4'd7;
    localparam logic [3:0] E_GT     = 4'd8;
    localparam logic [3:0] E_STRAY  = 4'd9;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  text_char;
        logic [3:0]  error_code;
        logic        line_done;
    } t_tok;

    localparam t_tok TOK_NONE = '{default: '0};

endpackage

/* hw/rtl/assembler_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// assembler_line_tokenizer
// Lexes an assembly source line, one byte per cycle, into a token stream.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle; the byte's tokens (zero, one or two) are
// computed in one pass and held in a two-entry result register that drains
// one token per cycle. A byte that yields two tokens blocks input while the second
// one drains; a one-token byte sustains one byte
// per cycle as long as the output side takes one token per cycle.
module assembler_line_tokenizer
    import alt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_kind,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_text_char,
    output logic [3:0]         o_error_code,
    output logic               o_line_done
);

    t_mode       r_mode, n_mode;
    logic [31:0] r_hex, n_hex, r_dec, n_dec, r_bin, n_bin, r_hexb, n_hexb, r_binb, n_binb;
    logic [2:0]  r_flags, n_flags;
    logic [7:0]  r_last, n_last, r_chv, n_chv;
    logic [1:0]  r_wlen, n_wlen;
    logic        r_af, n_af;
    logic [31:0] r_slen, n_slen;

    t_tok        r_q0, r_q1;
    logic [1:0]  r_cnt;
    t_tok        t0, t1;
    logic [1:0]  tn;

    logic [7:0]  c;
    logic        acc, pop;
    assign c = i_char_in;

    function automatic logic is_alpha(input logic [7:0] x);
        return (x >= 8'h41 && x <= 8'h5A) || (x >= 8'h61 && x <= 8'h7A);
    endfunction
    function automatic logic is_dig(input logic [7:0] x);
        return x >= 8'h30 && x <= 8'h39;
    endfunction
    function automatic logic id_first(input logic [7:0] x);
        return is_alpha(x) || x == 8'h5F || x == 8'h2E;
    endfunction
    function automatic logic [7:0] upper(input logic [7:0] x);
        return (x >= 8'h61 && x <= 8'h7A) ? x - 8'd32 : x;
    endfunction
    function automatic logic [4:0] hexval(input logic [7:0] x);
        if (is_dig(x)) return 5'(x - 8'h30);
        if (x >= 8'h41 && x <= 8'h46) return 5'(x - 8'h41 + 8'd10);
        if (x >= 8'h61 && x <= 8'h66) return 5'(x - 8'h61 + 8'd10);
        return 5'd16;
    endfunction
    function automatic logic [7:0] unesc(input logic [7:0] x);
        case (x)
            8'h6E:   return 8'd10;
            8'h74:   return 8'd9;
            8'h72:   return 8'd13;
            8'h30:   return 8'd0;
            default: return x;
        endcase
    endfunction
    function automatic t_tok mk(input logic [4:0] k, input logic [31:0] v,
                                input logic [7:0] t, input logic [3:0] e,
                                input logic d);
        t_tok r;
        r.kind = k; r.value = v; r.text_char = t; r.error_code = e; r.line_done = d;
        return r;
    endfunction

    logic [4:0] hv;
    assign hv = hexval(c);

    always_comb begin
        logic       do_idle;
        logic       e2;
        t_tok       first, second;
        logic [1:0] cnt;
        logic [4:0] lhv;
        n_mode = r_mode; n_hex = r_hex; n_dec = r_dec; n_bin = r_bin;
        n_hexb = r_hexb; n_binb = r_binb; n_flags = r_flags; n_last = r_last;
        n_chv = r_chv; n_wlen = r_wlen; n_af = r_af; n_slen = r_slen;
        do_idle = 1'b0;
        first = TOK_NONE; second = TOK_NONE; cnt = 2'd0; e2 = 1'b0;
        lhv = hexval(r_last);
        unique case (r_mode)
            M_SKIP: ;
            M_IDENT: begin
                if (id_first(c) || is_dig(c)) begin
                    if (r_wlen == 2'd1) n_af = r_af & (upper(c) == 8'h46);
                    if (r_wlen != 2'd3) n_wlen = r_wlen + 2'd1;
                    first = mk(K_IDCHAR, '0, upper(c), E_NONE, 1'b0); cnt = 2'd1;
                end else if (c == 8'h27 && r_wlen == 2'd2 && r_af) begin
                    n_mode = M_IDLE;
                    first = mk(K_IDCHAR, '0, 8'h27, E_NONE, 1'b0);
                    second = mk(K_IDEND, '0, '0, E_NONE, 1'b0); cnt = 2'd2;
                end else begin
                    first = mk(K_IDEND, '0, '0, E_NONE, 1'b0); cnt = 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_NUM: begin
                if ((c == 8'h78 || c == 8'h58) && r_wlen == 2'd1 && r_last == 8'h30) begin
                    n_mode = M_HEXX; n_hex = '0;
                end else if (is_alpha(c) || is_dig(c)) begin
                    n_flags = r_flags;
                    if (lhv > 5'd15) n_flags[0] = 1'b0;
                    if (!is_dig(c)) n_flags[1] = 1'b0;
                    if (r_last != 8'h30 && r_last != 8'h31) n_flags[2] = 1'b0;
                    n_hexb = r_hex; n_binb = r_bin;
                    n_hex = {r_hex[27:0], 4'd0} + 32'((hv < 5'd16) ? hv[3:0] : 4'd0);
                    n_dec = {r_dec[28:0], 3'd0} + {r_dec[30:0], 1'b0}
                          + 32'(is_dig(c) ? c[3:0] : 4'd0);
                    n_bin = {r_bin[30:0], c == 8'h31};
                    n_last = c;
                    if (r_wlen != 2'd3) n_wlen = r_wlen + 2'd1;
                end else begin
                    cnt = 2'd1;
                    if (r_wlen > 2'd1 && (r_last == 8'h68 || r_last == 8'h48)) begin
                        if (!r_flags[0]) e2 = 1'b1;
                        first = r_flags[0] ? mk(K_NUM, r_hexb, '0, E_NONE, 1'b0)
                                           : mk(K_ERR, '0, '0, E_HEX, 1'b1);
                    end else if (r_wlen > 2'd1 && (r_last == 8'h62 || r_last == 8'h42)) begin
                        if (!r_flags[2]) e2 = 1'b1;
                        first = r_flags[2] ? mk(K_NUM, r_binb, '0, E_NONE, 1'b0)
                                           : mk(K_ERR, '0, '0, E_BIN, 1'b1);
                    end else begin
                        if (!r_flags[1]) e2 = 1'b1;
                        first = r_flags[1] ? mk(K_NUM, r_dec, '0, E_NONE, 1'b0)
                                           : mk(K_ERR, '0, '0, E_DEC, 1'b1);
                    end
                    if (e2) n_mode = M_SKIP;
                    else do_idle = 1'b1;
                end
            end
            M_HEXX, M_HEXD: begin
                if (hv < 5'd16) n_hex = {r_hex[27:0], hv[3:0]};
                else begin
                    first = mk(K_NUM, r_hex, '0, E_NONE, 1'b0); cnt = 2'd1; do_idle = 1'b1;
                end
            end
            M_DOLLAR: begin
                if (hv < 5'd16) begin
                    n_hex = 32'(hv[3:0]); n_mode = M_HEXD;
                end else begin
                    first = mk(K_DOLLAR, '0, '0, E_NONE, 1'b0); cnt = 2'd1; do_idle = 1'b1;
                end
            end
            M_PERCENT: begin
                if (c == 8'h30 || c == 8'h31) begin
                    n_bin = 32'(c[0]); n_mode = M_BIN;
                end else begin
                    first = mk(K_PERCENT, '0, '0, E_NONE, 1'b0); cnt = 2'd1; do_idle = 1'b1;
                end
            end
            M_BIN: begin
                if (c == 8'h30 || c == 8'h31) n_bin = {r_bin[30:0], c[0]};
                else begin
                    first = mk(K_NUM, r_bin, '0, E_NONE, 1'b0); cnt = 2'd1; do_idle = 1'b1;
                end
            end
            M_STR: begin
                cnt = 2'd1;
                if (c == 8'h00) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_OPENS, 1'b1);
                end else if (c == 8'h22) begin
                    n_mode = M_IDLE; first = mk(K_STREND, r_slen, '0, E_NONE, 1'b0);
                end else if (c == 8'h5C) begin
                    n_mode = M_STRESC; cnt = 2'd0;
                end else begin
                    n_slen = r_slen + 32'd1; first = mk(K_STRCHAR, '0, c, E_NONE, 1'b0);
                end
            end
            M_STRESC: begin
                cnt = 2'd1;
                if (c == 8'h00) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_OPENS, 1'b1);
                end else begin
                    n_mode = M_STR; n_slen = r_slen + 32'd1;
                    first = mk(K_STRCHAR, '0, unesc(c), E_NONE, 1'b0);
                end
            end
            M_CHR: begin
                if (c == 8'h00 || c == 8'h27) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_CHAR, 1'b1); cnt = 2'd1;
                end else if (c == 8'h5C) n_mode = M_CHRESC;
                else begin
                    n_chv = c; n_mode = M_CHRCLOSE;
                end
            end
            M_CHRESC: begin
                if (c == 8'h00) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_OPENC, 1'b1); cnt = 2'd1;
                end else begin
                    n_chv = unesc(c); n_mode = M_CHRCLOSE;
                end
            end
            M_CHRCLOSE: begin
                cnt = 2'd1;
                if (c != 8'h27) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_OPENC, 1'b1);
                end else begin
                    n_mode = M_IDLE; first = mk(K_NUM, 32'(r_chv), '0, E_NONE, 1'b0);
                end
            end
            M_LT: begin
                cnt = 2'd1;
                if (c != 8'h3C) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_LT, 1'b1);
                end else begin
                    n_mode = M_IDLE; first = mk(K_SHL, '0, '0, E_NONE, 1'b0);
                end
            end
            M_GT: begin
                cnt = 2'd1;
                if (c != 8'h3E) begin
                    n_mode = M_SKIP; first = mk(K_ERR, '0, '0, E_GT, 1'b1);
                end else begin
                    n_mode = M_IDLE; first = mk(K_SHR, '0, '0, E_NONE, 1'b0);
                end
            end
            default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
            t_tok it;
            logic has;
            it = TOK_NONE; has = 1'b1;
            n_mode = M_IDLE;
            if (c == 8'h00 || c == 8'h3B || c == 8'h0A || c == 8'h0D) begin
                n_mode = M_SKIP; it = mk(K_EOL, '0, '0, E_NONE, 1'b1);
            end else if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
                has = 1'b0;
            end else if (id_first(c)) begin
                n_mode = M_IDENT; n_wlen = 2'd1; n_af = upper(c) == 8'h41;
                it = mk(K_IDCHAR, '0, upper(c), E_NONE, 1'b0);
            end else if (is_dig(c)) begin
                n_mode = M_NUM; n_hex = 32'(c[3:0]); n_dec = 32'(c[3:0]);
                n_bin = 32'(c == 8'h31); n_hexb = '0; n_binb = '0;
                n_flags = 3'b111; n_wlen = 2'd1; n_last = c; has = 1'b0;
            end else begin
                has = 1'b0;
                case (c)
                    8'h24: n_mode = M_DOLLAR;
                    8'h25: n_mode = M_PERCENT;
                    8'h22: begin n_mode = M_STR; n_slen = '0; end
                    8'h27: n_mode = M_CHR;
                    8'h3C: n_mode = M_LT;
                    8'h3E: n_mode = M_GT;
                    8'h2C: begin it = mk(K_PUNCT0,         '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h28: begin it = mk(K_PUNCT0 + 5'd1,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h29: begin it = mk(K_PUNCT0 + 5'd2,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h3A: begin it = mk(K_PUNCT0 + 5'd3,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h2B: begin it = mk(K_PUNCT0 + 5'd4,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h2D: begin it = mk(K_PUNCT0 + 5'd5,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h2A: begin it = mk(K_PUNCT0 + 5'd6,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h2F: begin it = mk(K_PUNCT0 + 5'd7,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h26: begin it = mk(K_PUNCT0 + 5'd8,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h7C: begin it = mk(K_PUNCT0 + 5'd9,  '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h5E: begin it = mk(K_PUNCT0 + 5'd10, '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    8'h7E: begin it = mk(K_PUNCT0 + 5'd11, '0, '0, E_NONE, 1'b0); has = 1'b1; end
                    default: begin
                        n_mode = M_SKIP; it = mk(K_ERR, '0, '0, E_STRAY, 1'b1); has = 1'b1;
                    end
                endcase
            end
            if (has) begin
                if (cnt == 2'd0) first = it;
                else second = it;
                cnt = cnt + 2'd1;
            end
        end
        if (c == 8'h00) n_mode = M_IDLE;
        t0 = first; t1 = second; tn = cnt;
    end

    assign o_valid = r_cnt != 2'd0;
    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_cnt == 2'd2) || (r_cnt == 2'd1 && !pop);
    assign acc     = i_valid && !o_stall;

    assign o_kind       = r_q0.kind;
    assign o_value      = signed'(r_q0.value);
    assign o_text_char  = r_q0.text_char;
    assign o_error_code = r_q0.error_code;
    assign o_line_done  = r_q0.line_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_hex <= '0; r_dec <= '0; r_bin <= '0;
            r_hexb <= '0; r_binb <= '0; r_flags <= 3'b111; r_last <= '0;
            r_wlen <= '0; r_af <= 1'b0; r_slen <= '0; r_chv <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                r_mode <= n_mode; r_hex <= n_hex; r_dec <= n_dec; r_bin <= n_bin;
                r_hexb <= n_hexb; r_binb <= n_binb; r_flags <= n_flags; r_last <= n_last;
                r_wlen <= n_wlen; r_af <= n_af; r_slen <= n_slen; r_chv <= n_chv;
                r_q0 <= t0; r_q1 <= t1; r_cnt <= tn;
            end else if (pop) begin
                r_q0 <= r_q1; r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall)
        else $error("input taken with two tokens pending");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("token count out of range");
    a_eol_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_char_in == 8'h00) |=> (r_mode == M_IDLE))
        else $error("line end did not return to idle");
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_ERR) |-> o_line_done)
        else $error("error token without line done");
`endif

endmodule

/* tb/sv/assembler_line_tokenizer_tb.sv */
// ----------------------------------------------------------------------------
// assembler_line_tokenizer_tb
// Self-checking bench for the assembly line tokenizer. Source lines go in one
// word per handshake with random bursts and gaps on the input side. The output
// side stalls on its own pattern. A cycle-free lexer model predicts every
// token, and each token is compared field by field as it is accepted.
// ----------------------------------------------------------------------------
module assembler_line_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alt_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_char_in = 8'd0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [4:0]         o_kind;
    logic signed [31:0] o_value;
    logic [7:0]         o_text_char;
    logic [3:0]         o_error_code;
    logic               o_line_done;

    assembler_line_tokenizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_char_in(i_char_in), .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_value(o_value), .o_text_char(o_text_char),
        .o_error_code(o_error_code), .o_line_done(o_line_done)
    );

    initial forever #4 i_clk = ~i_clk;

    // lexer state
    t_mode       lx_mode = M_IDLE;
    logic [31:0] hx = '0, dc = '0, bn = '0, hx_prev = '0, bn_prev = '0;
    logic [31:0] slen = '0;
    logic [2:0]  dflags = 3'b111;
    logic [7:0]  last_c = '0, chval = '0;
    logic [1:0]  wlen = '0;
    logic        af = 1'b0;
    int          n_emit;

    t_tok tok_expected[$];
    int   errors = 0;
    int   words_sent = 0;
    int   toks_checked = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit id_first(logic [7:0] c);
        return is_alpha(c) || c == "_" || c == ".";
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [4:0] hexv(logic [7:0] c);
        if (is_dig(c)) return 5'(c - 8'h30);
        if (c >= "A" && c <= "F") return 5'(c - 8'h41 + 8'd10);
        if (c >= "a" && c <= "f") return 5'(c - 8'h61 + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] unesc(logic [7:0] c);
        case (c)
            "n": return 8'd10;
            "t": return 8'd9;
            "r": return 8'd13;
            "0": return 8'd0;
            default: return c;
        endcase
    endfunction

    task automatic put(logic [4:0] k, logic [31:0] v, logic [7:0] t, logic [3:0] e,
                       logic d);
        t_tok tk;
        if (n_emit < 2) begin
            tk.kind = k; tk.value = v; tk.text_char = t; tk.error_code = e;
            tk.line_done = d;
            tok_expected.push_back(tk);
        end
        n_emit++;
    endtask

    task automatic bail(logic [3:0] code);
        lx_mode = M_SKIP;
        put(K_ERR, 0, 0, code, 1'b1);
    endtask

    task automatic lex_idle(logic [7:0] c);
        logic [4:0] pk;
        if (c == 0 || c == ";" || c == 8'h0A || c == 8'h0D) begin
            lx_mode = M_SKIP;
            put(K_EOL, 0, 0, E_NONE, 1'b1);
        end else if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
        end else if (id_first(c)) begin
            lx_mode = M_IDENT;
            wlen = 2'd1;
            af = (upcase(c) == "A");
            put(K_IDCHAR, 0, upcase(c), E_NONE, 1'b0);
        end else if (is_dig(c)) begin
            lx_mode = M_NUM;
            hx = 32'(c - 8'h30); dc = 32'(c - 8'h30); bn = 32'(c == "1");
            hx_prev = 0; bn_prev = 0; dflags = 3'b111; wlen = 2'd1; last_c = c;
        end else if (c == "$") lx_mode = M_DOLLAR;
        else if (c == "%") lx_mode = M_PERCENT;
        else if (c == "\"") begin
            lx_mode = M_STR;
            slen = 0;
        end else if (c == "'") lx_mode = M_CHR;
        else if (c == "<") lx_mode = M_LT;
        else if (c == ">") lx_mode = M_GT;
        else begin
            pk = 5'd31;
            case (c)
                ",": pk = K_PUNCT0;
                "(": pk = K_PUNCT0 + 5'd1;
                ")": pk = K_PUNCT0 + 5'd2;
                ":": pk = K_PUNCT0 + 5'd3;
                "+": pk = K_PUNCT0 + 5'd4;
                "-": pk = K_PUNCT0 + 5'd5;
                "*": pk = K_PUNCT0 + 5'd6;
                "/": pk = K_PUNCT0 + 5'd7;
                "&": pk = K_PUNCT0 + 5'd8;
                "|": pk = K_PUNCT0 + 5'd9;
                "^": pk = K_PUNCT0 + 5'd10;
                "~": pk = K_PUNCT0 + 5'd11;
                default: pk = 5'd31;
            endcase
            if (pk != 5'd31) put(pk, 0, 0, E_NONE, 1'b0);
            else bail(E_STRAY);
        end
    endtask

    task automatic close_number();
        if (wlen > 1 && (last_c == "h" || last_c == "H")) begin
            if (!dflags[0]) bail(E_HEX);
            else put(K_NUM, hx_prev, 0, E_NONE, 1'b0);
        end else if (wlen > 1 && (last_c == "b" || last_c == "B")) begin
            if (!dflags[2]) bail(E_BIN);
            else put(K_NUM, bn_prev, 0, E_NONE, 1'b0);
        end else if (!dflags[1]) bail(E_DEC);
        else put(K_NUM, dc, 0, E_NONE, 1'b0);
    endtask

    task automatic predict_word(logic [7:0] c);
        logic [4:0] hv;
        hv = hexv(c);
        n_emit = 0;
        case (lx_mode)
            M_SKIP: ;
            M_IDENT: begin
                if (id_first(c) || is_dig(c)) begin
                    if (wlen == 1) af = af & (upcase(c) == "F");
                    if (wlen < 3) wlen++;
                    put(K_IDCHAR, 0, upcase(c), E_NONE, 1'b0);
                end else begin
                    lx_mode = M_IDLE;
                    if (c == "'" && wlen == 2 && af) begin
                        put(K_IDCHAR, 0, "'", E_NONE, 1'b0);
                        put(K_IDEND, 0, 0, E_NONE, 1'b0);
                    end else begin
                        put(K_IDEND, 0, 0, E_NONE, 1'b0);
                        lex_idle(c);
                    end
                end
            end
            M_NUM: begin
                if ((c == "x" || c == "X") && wlen == 1 && last_c == "0") begin
                    lx_mode = M_HEXX;
                    hx = 0;
                end else if (is_alpha(c) || is_dig(c)) begin
                    if (hexv(last_c) > 15) dflags[0] = 1'b0;
                    if (!is_dig(c)) dflags[1] = 1'b0;
                    if (last_c != "0" && last_c != "1") dflags[2] = 1'b0;
                    hx_prev = hx;
                    bn_prev = bn;
                    hx = hx * 32'd16 + ((hv < 16) ? 32'(hv) : 32'd0);
                    dc = dc * 32'd10 + (is_dig(c) ? 32'(c - 8'h30) : 32'd0);
                    bn = bn * 32'd2 + 32'(c == "1");
                    last_c = c;
                    if (wlen < 3) wlen++;
                end else begin
                    lx_mode = M_IDLE;
                    close_number();
                    if (lx_mode != M_SKIP) lex_idle(c);
                end
            end
            M_HEXX, M_HEXD: begin
                if (hv < 16) hx = hx * 32'd16 + 32'(hv);
                else begin
                    lx_mode = M_IDLE;
                    put(K_NUM, hx, 0, E_NONE, 1'b0);
                    lex_idle(c);
                end
            end
            M_DOLLAR: begin
                if (hv < 16) begin
                    hx = 32'(hv);
                    lx_mode = M_HEXD;
                end else begin
                    lx_mode = M_IDLE;
                    put(K_DOLLAR, 0, 0, E_NONE, 1'b0);
                    lex_idle(c);
                end
            end
            M_PERCENT: begin
                if (c == "0" || c == "1") begin
                    bn = 32'(c[0]);
                    lx_mode = M_BIN;
                end else begin
                    lx_mode = M_IDLE;
                    put(K_PERCENT, 0, 0, E_NONE, 1'b0);
                    lex_idle(c);
                end
            end
            M_BIN: begin
                if (c == "0" || c == "1") bn = bn * 32'd2 + 32'(c[0]);
                else begin
                    lx_mode = M_IDLE;
                    put(K_NUM, bn, 0, E_NONE, 1'b0);
                    lex_idle(c);
                end
            end
            M_STR: begin
                if (c == 0) bail(E_OPENS);
                else if (c == "\"") begin
                    lx_mode = M_IDLE;
                    put(K_STREND, slen, 0, E_NONE, 1'b0);
                end else if (c == "\\") lx_mode = M_STRESC;
                else begin
                    slen++;
                    put(K_STRCHAR, 0, c, E_NONE, 1'b0);
                end
            end
            M_STRESC: begin
                if (c == 0) bail(E_OPENS);
                else begin
                    lx_mode = M_STR;
                    slen++;
                    put(K_STRCHAR, 0, unesc(c), E_NONE, 1'b0);
                end
            end
            M_CHR: begin
                if (c == 0 || c == "'") bail(E_CHAR);
                else if (c == "\\") lx_mode = M_CHRESC;
                else begin
                    chval = c;
                    lx_mode = M_CHRCLOSE;
                end
            end
            M_CHRESC: begin
                if (c == 0) bail(E_OPENC);
                else begin
                    chval = unesc(c);
                    lx_mode = M_CHRCLOSE;
                end
            end
            M_CHRCLOSE: begin
                if (c != "'") bail(E_OPENC);
                else begin
                    lx_mode = M_IDLE;
                    put(K_NUM, 32'(chval), 0, E_NONE, 1'b0);
                end
            end
            M_LT: begin
                if (c != "<") bail(E_LT);
                else begin
                    lx_mode = M_IDLE;
                    put(K_SHL, 0, 0, E_NONE, 1'b0);
                end
            end
            M_GT: begin
                if (c != ">") bail(E_GT);
                else begin
                    lx_mode = M_IDLE;
                    put(K_SHR, 0, 0, E_NONE, 1'b0);
                end
            end
            default: begin
                lx_mode = M_IDLE;
                lex_idle(c);
            end
        endcase
        if (c == 0) lx_mode = M_IDLE;
    endtask

    task automatic send_word(logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(c);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_word(8'd0);
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: expected %0h got %0h (token %0d)", what, exp_v, got_v,
                     toks_checked);
    endtask

    always @(posedge i_clk) begin
        t_tok tk;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tok_expected.size() == 0) report("unexpected token kind", 0, 32'(o_kind));
            else begin
                tk = tok_expected.pop_front();
                if (o_kind !== tk.kind) report("kind", 32'(tk.kind), 32'(o_kind));
                if (o_value !== tk.value) report("value", tk.value, o_value);
                if (o_text_char !== tk.text_char)
                    report("text_char", 32'(tk.text_char), 32'(o_text_char));
                if (o_error_code !== tk.error_code)
                    report("error_code", 32'(tk.error_code), 32'(o_error_code));
                if (o_line_done !== tk.line_done)
                    report("line_done", 32'(tk.line_done), 32'(o_line_done));
            end
            toks_checked++;
        end
    end

    int stall_pct = 0;
    int stall_hold = 0;
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 20;
                3: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_hold = $urandom_range(20, 200);
        end
        stall_hold--;
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic send_fragment();
        string hexd = "0123456789abcdefABCDEF";
        string idc = "abcdefxyzAFHLQ_.0123456789";
        int n;
        case ($urandom_range(0, 13))
            0: begin
                send_word(pick("abcfhlxyzABFHZ_."));
                n = $urandom_range(0, 6);
                repeat (n) send_word(pick(idc));
            end
            1: send_text($urandom_range(0, 1) ? "AF'" : ($urandom_range(0, 1) ? "af'" : "ax'"));
            2: begin
                n = $urandom_range(1, 12);
                repeat (n) send_word(pick("0123456789"));
            end
            3: begin
                send_text($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(0, 9);
                repeat (n) send_word(pick(hexd));
            end
            4: begin
                send_word("$");
                n = $urandom_range(0, 9);
                repeat (n) send_word(pick(hexd));
            end
            5: begin
                send_word("%");
                n = $urandom_range(0, 34);
                repeat (n) send_word(pick("01"));
            end
            6: begin
                send_word(pick("0123456789"));
                n = $urandom_range(0, 6);
                repeat (n) send_word($urandom_range(0, 7) == 0 ? pick("gxzq") : pick(hexd));
                send_word(pick("hH"));
            end
            7: begin
                n = $urandom_range(1, 34);
                repeat (n) send_word($urandom_range(0, 9) == 0 ? pick("29") : pick("01"));
                send_word(pick("bB"));
            end
            8: begin
                send_word(pick("0123456789"));
                n = $urandom_range(1, 4);
                repeat (n) send_word(pick("0123456789abhzBHxX"));
            end
            9: begin
                send_word("\"");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_word("\\");
                        send_word($urandom_range(0, 1) ? pick("ntr0\\\"")
                                                       : 8'($urandom_range(1, 255)));
                    end else send_word(pick("abc XYZ,;'<>$%\t") ^ ($urandom_range(0, 5) == 0 ?
                                       8'h80 : 8'h00));
                end
                if ($urandom_range(0, 7) != 0) send_word("\"");
            end
            10: begin
                send_word("'");
                case ($urandom_range(0, 5))
                    0: send_text("'");
                    1: send_text("\\");
                    2: send_text("ab");
                    3: begin
                        send_word("\\");
                        send_word(pick("ntr0qx'"));
                        send_word("'");
                    end
                    default: begin
                        send_word(8'($urandom_range(1, 255)));
                        send_word("'");
                    end
                endcase
            end
            11: begin
                case ($urandom_range(0, 5))
                    0: send_text("<<");
                    1: send_text(">>");
                    2: begin send_word("<"); send_word(pick("a1 >")); end
                    3: begin send_word(">"); send_word(pick("a1 <")); end
                    default: send_word(pick(",():+-*/&|^~"));
                endcase
            end
            12: send_word(8'($urandom_range(1, 255)));
            default: begin
                send_word(pick(";\015\n"));
                n = $urandom_range(0, 5);
                repeat (n) send_word(8'($urandom_range(1, 255)));
            end
        endcase
    endtask

    task automatic test_identifiers();
        send_line("ld a,(ix+12)");
        send_line("ex af,af'");
        send_line("_lbl.x:AF Ab'");
    endtask

    task automatic test_numbers();
        send_line("0x 0xFFFFffff 4294967296 $ $1aF %");
        send_line("%1011 0ffh 101b 12b 1h 9fzh 12q");
        send_line("99999999999 0x123456789 7");
    endtask

    task automatic test_strings_and_chars();
        send_line("\"a\\n\\t\\r\\0\\\\b\" 'x' '\\n'");
        send_line("\"open");
        send_line("\"esc\\");
        send_line("''");
        send_line("'\\");
        send_line("'ab'");
    endtask

    task automatic test_punct_and_errors();
        send_line(",():+-*/&|^~<<>>$ %,");
        send_line("a <b");
        send_line("a >b");
        send_line("a ; comment \"x");
        send_line("x\015y");
        send_line("b\n");
        send_line("z @ more");
        send_word(8'hFF);
        send_word(8'h80);
        send_word(8'd0);
        send_word(8'd0);
    endtask

    task automatic test_random_lines();
        int n;
        while (words_sent < 500) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                send_fragment();
                case ($urandom_range(0, 5))
                    0, 1: send_word(" ");
                    2: send_word(8'h09);
                    3: send_word(",");
                    default: ;
                endcase
            end
            send_word(8'd0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_identifiers();
        test_numbers();
        test_strings_and_chars();
        test_punct_and_errors();
        test_random_lines();
        i_valid <= 1'b0;
        while (tok_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d source bytes, checked %0d tokens", words_sent, toks_checked);
        $display("covered identifiers, all number forms, strings, chars, punctuation, errors");
        if (errors == 0 && tok_expected.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
